// ===== sv/lef_pkg.sv =====
`default_nettype none
// ============================================================================
// lef_pkg - shared types and constants of the 3x3 local extrema finder
// Field widths, configuration register indexes and the structs that carry
// one 3x3 neighbourhood to the comparator and its verdict back.
// ============================================================================
package lef_pkg;

  localparam int SAMPLE_W    = 16;  // element value width
  localparam int POS_W       = 6;   // row and column fields of a result
  localparam int CNT_W       = 13;  // maximum and minimum counts
  localparam int SUM_W       = 29;  // extremum sum
  localparam int CFG_W       = 7;   // size registers
  localparam int CFG_IDX_W   = 1;   // configuration register index
  localparam int SIZE_W      = 13;  // internal width for size compares
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 88;
  localparam int TUSER_OUT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_LIMIT  = 13'd8191;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // v[row][col], centre at [1][1]; ok marks neighbours that exist
  typedef struct packed {
    logic [2:0][2:0][SAMPLE_W-1:0] v;
    logic [2:0][2:0]               ok;
  } hood_t;

  typedef struct packed {
    logic is_max;
    logic is_min;
  } verdict_t;

endpackage
`default_nettype wire

// ===== sv/lef_ram.sv =====
`default_nettype none
// ============================================================================
// lef_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data. A read at the
// address being written returns the old contents.
// ============================================================================
module lef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/lef_cmp.sv =====
`default_nettype none
// ============================================================================
// lef_cmp - strict extremum test over one 3x3 neighbourhood
// Compares the centre with every existing neighbour; a centre without any
// neighbour is both a maximum and a minimum.
// ============================================================================
module lef_cmp import lef_pkg::*; (
  input  hood_t    hood_i,
  output verdict_t verdict_o
);

  sample_t centre;

  always_comb begin
    centre           = $signed(hood_i.v[1][1]);
    verdict_o.is_max = 1'b1;
    verdict_o.is_min = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && hood_i.ok[i][j]) begin
          if (centre <= $signed(hood_i.v[i][j])) begin
            verdict_o.is_max = 1'b0;
          end
          if (centre >= $signed(hood_i.v[i][j])) begin
            verdict_o.is_min = 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/local_extrema_3x3_finder_top.sv =====
`default_nettype none
// ============================================================================
// local_extrema_3x3_finder_top - strict local extrema over a 3x3 window
// Elements of a signed array arrive in raster order on the in_ stream, one
// word per element; the array size is set through the cfg_ write port
// (index 0 rows, index 1 columns, 0 acts as 1, values above the maximum
// clamp). Any register write restarts the image at element (0,0); write only
// while the block is idle.
// Each element, once its neighbours are known, leaves as one word on the
// out_ stream with its position, value, max/min flags, running counts and
// running sum; the final word of the image carries tlast.
// The first result of an input word passes the decision stage and then the
// result register. An input word causes zero to four results and holds the
// decision stage until its results are emitted, one result per cycle
// through the shared comparator while the output does not stall; in the body
// of an image that is one word per cycle.
// Two line RAMs (MAX_COLUMNS deep) hold the two rows above; their reads are
// issued at acceptance so the data is ready in the decision stage.
// Reset (rst_n low, synchronous) empties both stages, sets both sizes to
// 64 and restarts the image. While out_tvalid is high and out_tready low the
// result register holds; a decision-stage word with results pending then holds and in_tready drops.
// ============================================================================
module local_extrema_3x3_finder_top import lef_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // [15:0] element_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [5:0] row, [11:6] column, [27:12] value, [40:28] maximum_count,
  // [53:41] minimum_count, [82:54] extremum_sum, [87:83] zero
  output logic [TDATA_OUT_W-1:0] out_tdata,
  output logic [TUSER_OUT_W-1:0] out_tuser,  // [0] is_maximum, [1] is_minimum
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int CPW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RPW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUMX_W = SUM_W + 2;
  localparam int PAD_W  = TDATA_OUT_W - (2 * POS_W + SAMPLE_W + 2 * CNT_W + SUM_W);
  localparam logic signed [SUMX_W-1:0] SUM_HI = SUMX_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUMX_W-1:0] SUM_LO = -SUM_HI - SUMX_W'(1);

  typedef enum logic [1:0] {
    SLOT_DIAG,       // (r-1, c-1)
    SLOT_EDGE,       // (r-1, c) at row end
    SLOT_LAST_DIAG,  // (r, c-1) on the last row
    SLOT_LAST_EDGE   // (r, c), final element of the image
  } slot_t;

  // --------------------------------------------------------------------------
  // Configuration and raster position
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  row_count_r, col_count_r;
  logic [SIZE_W-1:0] rows_eff, cols_eff;
  logic [RPW-1:0]    row_pos_r;
  logic [CPW-1:0]    col_pos_r;
  logic              row_end, last_row, accept;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (SIZE_W'(row_count_r) > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = SIZE_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (SIZE_W'(col_count_r) > SIZE_W'(MAX_COLUMNS)) begin
      cols_eff = SIZE_W'(MAX_COLUMNS);
    end else begin
      cols_eff = SIZE_W'(col_count_r);
    end
  end

  assign row_end  = (SIZE_W'(col_pos_r) + SIZE_W'(1)) >= cols_eff;
  assign last_row = (SIZE_W'(row_pos_r) + SIZE_W'(1)) >= rows_eff;
  assign accept   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= SIZE_RESET;
      col_count_r <= SIZE_RESET;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r <= cfg_wdata;
        CFG_COLUMN_COUNT: col_count_r <= cfg_wdata;
        default:          ;
      endcase
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos_r <= '0;
        row_pos_r <= last_row ? '0 : row_pos_r + RPW'(1);
      end else begin
        col_pos_r <= col_pos_r + CPW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Decision stage: one input word, its pending results and the new column
  // --------------------------------------------------------------------------
  logic           s1_val_r;
  sample_t        s1_value_r;
  logic [RPW-1:0] s1_row_r;
  logic [CPW-1:0] s1_col_r;
  logic [3:0]     s1_pend_r;
  logic           byp_r;
  sample_t        byp_top_r, byp_mid_r;
  sample_t        win_top_r [2];
  sample_t        win_mid_r [2];
  sample_t        win_bot_r [2];
  logic [SAMPLE_W-1:0] older_q, prev_q;
  sample_t        col_top, col_mid;
  slot_t          sel;
  logic [3:0]     sel_oh;
  logic           out_free, emit, retire;

  assign col_top = byp_r ? byp_top_r : $signed(older_q);
  assign col_mid = byp_r ? byp_mid_r : $signed(prev_q);

  always_comb begin
    if (s1_pend_r[0]) begin
      sel = SLOT_DIAG;
    end else if (s1_pend_r[1]) begin
      sel = SLOT_EDGE;
    end else if (s1_pend_r[2]) begin
      sel = SLOT_LAST_DIAG;
    end else begin
      sel = SLOT_LAST_EDGE;
    end
  end

  assign sel_oh    = 4'(1) << sel;
  assign out_free  = !out_tvalid || out_tready;
  assign emit      = s1_val_r && (s1_pend_r != '0) && out_free;
  assign retire    = s1_val_r && ((s1_pend_r == '0) ||
                                  (emit && ((s1_pend_r & ~sel_oh) == '0)));
  assign in_tready = !s1_val_r || retire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_val_r  <= 1'b0;
      s1_pend_r <= '0;
      byp_r     <= 1'b0;
    end else if (accept) begin
      s1_val_r  <= 1'b1;
      s1_pend_r <= {last_row && row_end,
                    last_row && (col_pos_r != '0),
                    (row_pos_r != '0) && row_end,
                    (row_pos_r != '0) && (col_pos_r != '0)};
      // same column written and read in one cycle: forward the write
      byp_r     <= retire && (col_pos_r == s1_col_r);
    end else if (retire) begin
      s1_val_r  <= 1'b0;
      s1_pend_r <= '0;
    end else if (emit) begin
      s1_pend_r <= s1_pend_r & ~sel_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= $signed(in_tdata[SAMPLE_W-1:0]);
      s1_row_r   <= row_pos_r;
      s1_col_r   <= col_pos_r;
      byp_top_r  <= col_mid;
      byp_mid_r  <= s1_value_r;
    end
    if (retire) begin
      win_top_r[0] <= win_top_r[1];
      win_mid_r[0] <= win_mid_r[1];
      win_bot_r[0] <= win_bot_r[1];
      win_top_r[1] <= col_top;
      win_mid_r[1] <= col_mid;
      win_bot_r[1] <= s1_value_r;
    end
  end

  // Line RAMs: rows r-2 and r-1; advance both by one row at retire
  lef_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_older_ram (
    .clk   (clk),
    .we    (retire),
    .waddr (s1_col_r),
    .wdata (col_mid),
    .re    (accept),
    .raddr (col_pos_r),
    .rdata (older_q)
  );

  lef_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_prev_ram (
    .clk   (clk),
    .we    (retire),
    .waddr (s1_col_r),
    .wdata (s1_value_r),
    .re    (accept),
    .raddr (col_pos_r),
    .rdata (prev_q)
  );

  // --------------------------------------------------------------------------
  // Neighbourhood of the selected result: grid rows top/mid/bot/none,
  // columns c-2/c-1/c/none; the centre moves down and right by slot
  // --------------------------------------------------------------------------
  sample_t    grid_v [4][4];
  logic [3:0] row_ok, col_ok;
  logic       shift_r, shift_c;
  hood_t      hood;
  verdict_t   verdict;
  sample_t    centre;

  assign shift_c = (sel == SLOT_EDGE) || (sel == SLOT_LAST_EDGE);
  assign shift_r = (sel == SLOT_LAST_DIAG) || (sel == SLOT_LAST_EDGE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        grid_v[i][j] = '0;
      end
    end
    grid_v[0][0] = win_top_r[0];
    grid_v[0][1] = win_top_r[1];
    grid_v[0][2] = col_top;
    grid_v[1][0] = win_mid_r[0];
    grid_v[1][1] = win_mid_r[1];
    grid_v[1][2] = col_mid;
    grid_v[2][0] = win_bot_r[0];
    grid_v[2][1] = win_bot_r[1];
    grid_v[2][2] = s1_value_r;
    row_ok = {1'b0, 1'b1, s1_row_r != '0, SIZE_W'(s1_row_r) >= SIZE_W'(2)};
    col_ok = {1'b0, 1'b1, s1_col_r != '0, SIZE_W'(s1_col_r) >= SIZE_W'(2)};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hood.v[i][j]  = grid_v[2'(i) + {1'b0, shift_r}][2'(j) + {1'b0, shift_c}];
        hood.ok[i][j] = row_ok[2'(i) + {1'b0, shift_r}] &&
                        col_ok[2'(j) + {1'b0, shift_c}];
      end
    end
  end

  assign centre = $signed(hood.v[1][1]);

  lef_cmp u_cmp (
    .hood_i    (hood),
    .verdict_o (verdict)
  );

  // --------------------------------------------------------------------------
  // Running counts and sum, result register
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]         max_cnt_r, min_cnt_r, max_cnt_nxt, min_cnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUMX_W-1:0] centre_x, sum_x;
  logic [POS_W-1:0]         res_row, res_col;

  logic                     out_val_r;
  logic [POS_W-1:0]         out_row_r, out_col_r;
  sample_t                  out_value_r;
  logic                     out_max_r, out_min_r, out_last_r;
  logic [CNT_W-1:0]         out_maxc_r, out_minc_r;
  logic signed [SUM_W-1:0]  out_sum_r;

  always_comb begin
    max_cnt_nxt = max_cnt_r;
    min_cnt_nxt = min_cnt_r;
    if (verdict.is_max && (max_cnt_r != CNT_LIMIT)) begin
      max_cnt_nxt = max_cnt_r + CNT_W'(1);
    end
    if (verdict.is_min && (min_cnt_r != CNT_LIMIT)) begin
      min_cnt_nxt = min_cnt_r + CNT_W'(1);
    end
    centre_x = SUMX_W'(centre);
    sum_x    = SUMX_W'(sum_r) + (verdict.is_max ? centre_x : '0)
                              + (verdict.is_min ? centre_x : '0);
    if (sum_x > SUM_HI) begin
      sum_nxt = SUM_W'(SUM_HI);
    end else if (sum_x < SUM_LO) begin
      sum_nxt = SUM_W'(SUM_LO);
    end else begin
      sum_nxt = SUM_W'(sum_x);
    end
    res_row = shift_r ? POS_W'(s1_row_r) : POS_W'(s1_row_r - RPW'(1));
    res_col = shift_c ? POS_W'(s1_col_r) : POS_W'(s1_col_r - CPW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cnt_r <= '0;
      min_cnt_r <= '0;
      sum_r     <= '0;
    end else if (cfg_we || (emit && (sel == SLOT_LAST_EDGE))) begin
      // restart the image
      max_cnt_r <= '0;
      min_cnt_r <= '0;
      sum_r     <= '0;
    end else if (emit) begin
      max_cnt_r <= max_cnt_nxt;
      min_cnt_r <= min_cnt_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_val_r <= 1'b0;
    end else if (emit) begin
      out_val_r <= 1'b1;
    end else if (out_tready) begin
      out_val_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= res_row;
      out_col_r   <= res_col;
      out_value_r <= centre;
      out_max_r   <= verdict.is_max;
      out_min_r   <= verdict.is_min;
      out_maxc_r  <= max_cnt_nxt;
      out_minc_r  <= min_cnt_nxt;
      out_sum_r   <= sum_nxt;
      out_last_r  <= (sel == SLOT_LAST_EDGE);
    end
  end

  assign out_tvalid = out_val_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_sum_r, out_minc_r, out_maxc_r,
                       out_value_r, out_col_r, out_row_r};
  assign out_tuser  = {out_min_r, out_max_r};
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_last_restarts_totals: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (sel == SLOT_LAST_EDGE) |=> (max_cnt_r == '0) && (min_cnt_r == '0)
                                        && (sum_r == '0))
    else $error("running totals not cleared after the final word of an image");

  a_image_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end && last_row |=> (row_pos_r == '0) && (col_pos_r == '0))
    else $error("raster position not rewound at the end of an image");

  a_both_only_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tuser[1] |->
      (out_row_r == '0) && (out_col_r == '0) && out_tlast)
    else $error("word flagged both maximum and minimum outside a 1x1 image");

  a_retire_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_val_r && !retire |=> s1_val_r && ($countones(s1_pend_r) >= 1))
    else $error("decision stage lost a word with results still pending");

endmodule
`default_nettype wire
